### src/matrix3x3_inverse_defines.svh
// assertion macros shared by the matrix inverse rtl
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS
`define MI3_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MI3_ASSERT(lbl, prop, msg) \
    `MI3_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define MI3_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define MI3_ASSERT(lbl, prop, msg)
`endif

`endif

### src/mi3_pkg.sv
package mi3_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int PROD_W        = 2 * WORD_W;
    localparam int COF_W         = PROD_W;
    localparam int PL_W          = PROD_W + 1;
    // three row-0 terms, each below 2^94 in magnitude
    localparam int DET_W         = 97;
    localparam int DET_MAG_W     = DET_W - 1;
    localparam int Q_W           = WORD_W;
    localparam int N_ENT         = 9;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [COF_W-1:0]  t_cof;
    typedef t_word [N_ENT-1:0]        t_mat9;
    typedef t_cof [N_ENT-1:0]         t_cof9;

    typedef struct packed {
        t_word in_r0c0;
        t_word in_r0c1;
        t_word in_r0c2;
        t_word in_r1c0;
        t_word in_r1c1;
        t_word in_r1c2;
        t_word in_r2c0;
        t_word in_r2c1;
        t_word in_r2c2;
    } t_mi3_in;

    typedef struct packed {
        t_word out_r0c0;
        t_word out_r0c1;
        t_word out_r0c2;
        t_word out_r1c0;
        t_word out_r1c1;
        t_word out_r1c2;
        t_word out_r2c0;
        t_word out_r2c1;
        t_word out_r2c2;
        logic  singular;
        logic  overflow;
    } t_mi3_out;

    // cofactor k = m[x]*m[y] - m[z]*m[t], row-major flat indices
    localparam int unsigned COF_SEL [N_ENT][4] = '{
        '{4, 8, 5, 7},
        '{5, 6, 3, 8},
        '{3, 7, 4, 6},
        '{7, 2, 8, 1},
        '{8, 0, 6, 2},
        '{6, 1, 7, 0},
        '{1, 5, 2, 4},
        '{2, 3, 0, 5},
        '{0, 4, 1, 3}
    };

    localparam t_word SAT_MAX = t_word'(32'h7FFF_FFFF);
    localparam t_word SAT_MIN = t_word'(32'h8000_0000);

    function automatic logic [WORD_W-1:0] abs_word(t_word x);
        return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
    endfunction

endpackage

### src/mi3_stream_if.sv
interface mi3_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### src/mi3_cofactor.sv
module mi3_cofactor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_vld,
    input  mi3_pkg::t_mat9 i_mat,
    output logic           o_vld,
    output mi3_pkg::t_mat9 o_mat,
    output logic           o_piv_zero,
    output mi3_pkg::t_cof9 o_cof
);
    import mi3_pkg::*;

    typedef logic signed [PROD_W-1:0] t_prod;

    logic               r_vld1;
    logic               r_vld2;
    t_mat9              r_mat1;
    t_mat9              r_mat2;
    logic               r_piv_zero1;
    logic               r_piv_zero2;
    t_prod              r_prod_a [N_ENT];
    t_prod              r_prod_b [N_ENT];
    t_cof9              r_cof;
    logic [WORD_W-1:0]  mag0;
    logic [WORD_W-1:0]  mag1;
    logic [WORD_W-1:0]  mag2;
    logic               row0_win;
    logic               row1_win;
    logic               n_piv_zero;

    // pivot from column 0, ties fall through to row 2
    always_comb begin
        mag0       = abs_word(i_mat[0]);
        mag1       = abs_word(i_mat[3]);
        mag2       = abs_word(i_mat[6]);
        row0_win   = (mag1 < mag0) && (mag2 < mag0);
        row1_win   = (mag0 < mag1) && (mag2 < mag1);
        // a winning row 0 or row 1 pivot is never zero
        n_piv_zero = !row0_win && !row1_win && (i_mat[6] == '0);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    // stage 1 products, stage 2 cofactors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat1      <= i_mat;
            r_piv_zero1 <= n_piv_zero;
            for (int k = 0; k < N_ENT; k++) begin
                r_prod_a[k] <= PROD_W'(i_mat[COF_SEL[k][0]]) * PROD_W'(i_mat[COF_SEL[k][1]]);
                r_prod_b[k] <= PROD_W'(i_mat[COF_SEL[k][2]]) * PROD_W'(i_mat[COF_SEL[k][3]]);
            end
            r_mat2      <= r_mat1;
            r_piv_zero2 <= r_piv_zero1;
            for (int k = 0; k < N_ENT; k++) begin
                r_cof[k] <= r_prod_a[k] - r_prod_b[k];
            end
        end
    end

    assign o_vld      = r_vld2;
    assign o_mat      = r_mat2;
    assign o_piv_zero = r_piv_zero2;
    assign o_cof      = r_cof;
endmodule

### src/mi3_det.sv
`include "matrix3x3_inverse_defines.svh"

module mi3_det #(
    parameter  int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
    localparam int NUM_W     = mi3_pkg::COF_W - 1 + 2 * FRAC_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  mi3_pkg::t_mat9                        i_mat,
    input  logic                                  i_piv_zero,
    input  mi3_pkg::t_cof9                        i_cof,
    output logic                                  o_vld,
    output mi3_pkg::t_mat9                        o_mat,
    output logic                                  o_sing,
    output logic [mi3_pkg::N_ENT-1:0]             o_neg,
    output logic [mi3_pkg::N_ENT-1:0][NUM_W-1:0]  o_num,
    output logic [mi3_pkg::DET_MAG_W-1:0]         o_den
);
    import mi3_pkg::*;

    typedef logic signed [DET_W-1:0] t_det;

    logic                         r_vld3;
    logic                         r_vld4;
    logic                         r_vld5;
    logic                         r_vld6;
    t_mat9                        r_mat3;
    t_mat9                        r_mat4;
    t_mat9                        r_mat5;
    t_mat9                        r_mat6;
    t_cof9                        r_cof3;
    t_cof9                        r_cof4;
    t_cof9                        r_cof5;
    logic                         r_pz3;
    logic                         r_pz4;
    logic                         r_pz5;
    logic signed [PROD_W-1:0]     r_ph [3];
    logic signed [PL_W-1:0]       r_pl [3];
    t_det                         r_term [3];
    t_det                         r_det;
    logic                         r_sing;
    logic [N_ENT-1:0]             r_neg;
    logic [N_ENT-1:0][NUM_W-1:0]  r_num;
    logic [DET_MAG_W-1:0]         r_den;
    t_word                        cof_hi [3];
    logic signed [WORD_W:0]       cof_lo [3];
    logic [COF_W-1:0]             cof_mag [N_ENT];

    // split row-0 cofactors into signed high and unsigned low halves; magnitudes of the stage-5 cofactors
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            cof_hi[j] = t_word'(i_cof[j][COF_W-1:WORD_W]);
            cof_lo[j] = {1'b0, i_cof[j][WORD_W-1:0]};
        end
        for (int k = 0; k < N_ENT; k++) begin
            cof_mag[k] = r_cof5[k][COF_W-1] ? COF_W'(-r_cof5[k]) : COF_W'(r_cof5[k]);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
            r_vld6 <= 1'b0;
        end else if (i_en) begin
            r_vld3 <= i_vld;
            r_vld4 <= r_vld3;
            r_vld5 <= r_vld4;
            r_vld6 <= r_vld5;
        end
    end

    // stage 3 partial products, 4 terms, 5 det, 6 magnitudes and signs
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mat3 <= i_mat;
            r_cof3 <= i_cof;
            r_pz3  <= i_piv_zero;
            for (int j = 0; j < 3; j++) begin
                r_ph[j] <= PROD_W'(i_mat[j]) * PROD_W'(cof_hi[j]);
                r_pl[j] <= PL_W'(i_mat[j]) * PL_W'(cof_lo[j]);
            end

            r_mat4 <= r_mat3;
            r_cof4 <= r_cof3;
            r_pz4  <= r_pz3;
            for (int j = 0; j < 3; j++) begin
                r_term[j] <= (DET_W'(r_ph[j]) <<< WORD_W) + DET_W'(r_pl[j]);
            end

            r_mat5 <= r_mat4;
            r_cof5 <= r_cof4;
            r_pz5  <= r_pz4;
            r_det  <= r_term[0] + r_term[1] + r_term[2];

            r_mat6 <= r_mat5;
            r_sing <= r_pz5 || (r_det == '0);
            r_den  <= r_det[DET_W-1] ? DET_MAG_W'(-r_det) : DET_MAG_W'(r_det);
            for (int k = 0; k < N_ENT; k++) begin
                r_neg[k] <= r_cof5[k][COF_W-1] ^ r_det[DET_W-1];
                r_num[k] <= {cof_mag[k][COF_W-2:0], {(2 * FRAC_BITS){1'b0}}};
            end
        end
    end

    assign o_vld  = r_vld6;
    assign o_mat  = r_mat6;
    assign o_sing = r_sing;
    assign o_neg  = r_neg;
    assign o_num  = r_num;
    assign o_den  = r_den;

    `MI3_ASSERT(a_zero_det_sing, r_vld6 && (r_den == '0) |-> r_sing, "zero det not singular")
endmodule

### src/mi3_div_lane.sv
module mi3_div_lane #(
    parameter  int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF,
    localparam int NUM_W     = mi3_pkg::COF_W - 1 + 2 * FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [NUM_W-1:0]              i_num,
    input  logic [mi3_pkg::DET_MAG_W-1:0] i_den,
    input  logic                          i_neg,
    input  logic                          i_sing,
    input  mi3_pkg::t_word                i_byp,
    output mi3_pkg::t_word                o_res,
    output logic                          o_ovf
);
    import mi3_pkg::*;

    localparam int SHIFT_W = DET_MAG_W + Q_W + 1;
    localparam int DIV_W   = (NUM_W > SHIFT_W) ? NUM_W : SHIFT_W;

    typedef struct packed {
        logic [DET_MAG_W-1:0] den;
        logic                 neg;
        logic                 sing;
        logic                 big;
        t_word                byp;
    } t_side;

    logic [DIV_W-1:0] r_rem  [Q_W];
    logic [Q_W-1:0]   r_q    [Q_W+1];
    t_side            r_side [Q_W+1];
    t_word            r_res;
    logic             r_ovf;
    t_word            n_res;
    logic             n_ovf;

    // entry stage: a quotient of 2^32 or more saturates outright
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]       <= DIV_W'(i_num);
            r_q[0]         <= '0;
            r_side[0].den  <= i_den;
            r_side[0].neg  <= i_neg;
            r_side[0].sing <= i_sing;
            r_side[0].big  <= DIV_W'(i_num) >= (DIV_W'(i_den) << Q_W);
            r_side[0].byp  <= i_byp;
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < Q_W; k++) begin : g_bit
        localparam int B = Q_W - 1 - k;
        logic [DIV_W:0] trial;

        assign trial = {1'b0, r_rem[k]} - ({1'b0, DIV_W'(r_side[k].den)} << B);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                if (!trial[DIV_W]) begin
                    r_q[k+1] <= r_q[k] | (Q_W'(1) << B);
                end else begin
                    r_q[k+1] <= r_q[k];
                end
            end
        end

        if (k < Q_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= trial[DIV_W] ? r_rem[k] : trial[DIV_W-1:0];
                end
            end
        end
    end

    // sign, saturation and singular bypass
    always_comb begin
        n_res = t_word'(r_q[Q_W]);
        n_ovf = 1'b0;
        priority if (r_side[Q_W].sing) begin
            n_res = r_side[Q_W].byp;
        end else if (r_side[Q_W].big) begin
            n_ovf = 1'b1;
            n_res = r_side[Q_W].neg ? SAT_MIN : SAT_MAX;
        end else if (!r_side[Q_W].neg) begin
            if (r_q[Q_W][Q_W-1]) begin
                n_ovf = 1'b1;
                n_res = SAT_MAX;
            end
        end else begin
            if (r_q[Q_W][Q_W-1] && (r_q[Q_W][Q_W-2:0] != '0)) begin
                n_ovf = 1'b1;
                n_res = SAT_MIN;
            end else begin
                n_res = t_word'(-r_q[Q_W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_ovf <= n_ovf;
        end
    end

    assign o_res = r_res;
    assign o_ovf = r_ovf;
endmodule

### src/matrix3x3_inverse.sv
// 3x3 fixed-point matrix inverse, signed Q16.16 by default (FRAC_BITS fraction bits)
// i_in carries one matrix per beat (in_r0c0 .. in_r2c2, row-major); o_out carries
// the inverse (out_r0c0 .. out_r2c2) plus the singular and overflow flags.
// A beat moves at a rising edge with valid and ready both high.
// Throughput: one matrix per cycle while the output is not stalled, fully pipelined.
// Pipeline from the input beat to the output beat:
//   2 stages of cofactors, 4 stages of det and magnitudes, then nine divider
//   lanes of 34 stages each (range check, one stage per quotient bit, saturation).
// A zero det (or a zero pivot from column 0) gives singular = 1 and the input
// matrix unchanged on the outputs. Saturated entries set overflow.
// Reset clears every valid bit; the output goes invalid and i_in.ready is high.
// When the receiver holds o_out.ready low with a result waiting, the whole pipe
// freezes and i_in.ready drops in the same cycle; nothing is lost or repeated.
`include "matrix3x3_inverse_defines.svh"

module matrix3x3_inverse #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mi3_stream_if.sink   i_in,
    mi3_stream_if.source o_out
);
    import mi3_pkg::*;

    localparam int NUM_W       = COF_W - 1 + 2 * FRAC_BITS;
    localparam int LANE_STAGES = Q_W + 2;

    logic                          en;
    t_mat9                         in_mat;
    logic                          cof_vld;
    t_mat9                         cof_mat;
    logic                          cof_piv_zero;
    t_cof9                         cof_val;
    logic                          det_vld;
    t_mat9                         det_mat;
    logic                          det_sing;
    logic [N_ENT-1:0]              det_neg;
    logic [N_ENT-1:0][NUM_W-1:0]   det_num;
    logic [DET_MAG_W-1:0]          det_den;
    t_word                         lane_res [N_ENT];
    logic [N_ENT-1:0]              lane_ovf;
    logic [LANE_STAGES-1:0]        r_vld_div;
    logic [LANE_STAGES-1:0]        r_sing_div;

    // pipe advances unless a result is stuck at the output
    assign en         = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    // flatten the input beat, row-major
    assign in_mat[0] = i_in.payload.in_r0c0;
    assign in_mat[1] = i_in.payload.in_r0c1;
    assign in_mat[2] = i_in.payload.in_r0c2;
    assign in_mat[3] = i_in.payload.in_r1c0;
    assign in_mat[4] = i_in.payload.in_r1c1;
    assign in_mat[5] = i_in.payload.in_r1c2;
    assign in_mat[6] = i_in.payload.in_r2c0;
    assign in_mat[7] = i_in.payload.in_r2c1;
    assign in_mat[8] = i_in.payload.in_r2c2;

    mi3_cofactor u_cofactor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (i_in.valid),
        .i_mat      (in_mat),
        .o_vld      (cof_vld),
        .o_mat      (cof_mat),
        .o_piv_zero (cof_piv_zero),
        .o_cof      (cof_val)
    );

    mi3_det #(
        .FRAC_BITS (FRAC_BITS)
    ) u_det (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (cof_vld),
        .i_mat      (cof_mat),
        .i_piv_zero (cof_piv_zero),
        .i_cof      (cof_val),
        .o_vld      (det_vld),
        .o_mat      (det_mat),
        .o_sing     (det_sing),
        .o_neg      (det_neg),
        .o_num      (det_num),
        .o_den      (det_den)
    );

    // output row i column j divides cofactor (j, i)
    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            mi3_div_lane #(
                .FRAC_BITS (FRAC_BITS)
            ) u_lane (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_num  (det_num[j*3+i]),
                .i_den  (det_den),
                .i_neg  (det_neg[j*3+i]),
                .i_sing (det_sing),
                .i_byp  (det_mat[i*3+j]),
                .o_res  (lane_res[i*3+j]),
                .o_ovf  (lane_ovf[i*3+j])
            );
        end
    end

    // valid line alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_div <= '0;
        end else if (en) begin
            r_vld_div <= {r_vld_div[LANE_STAGES-2:0], det_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing_div <= {r_sing_div[LANE_STAGES-2:0], det_sing};
        end
    end

    // output beat
    assign o_out.valid            = r_vld_div[LANE_STAGES-1];
    assign o_out.payload.out_r0c0 = lane_res[0];
    assign o_out.payload.out_r0c1 = lane_res[1];
    assign o_out.payload.out_r0c2 = lane_res[2];
    assign o_out.payload.out_r1c0 = lane_res[3];
    assign o_out.payload.out_r1c1 = lane_res[4];
    assign o_out.payload.out_r1c2 = lane_res[5];
    assign o_out.payload.out_r2c0 = lane_res[6];
    assign o_out.payload.out_r2c1 = lane_res[7];
    assign o_out.payload.out_r2c2 = lane_res[8];
    assign o_out.payload.singular = r_sing_div[LANE_STAGES-1];
    assign o_out.payload.overflow = |lane_ovf;

    `MI3_ASSERT(a_sing_no_ovf, o_out.valid && o_out.payload.singular |-> !o_out.payload.overflow, "singular result flags overflow")
    `MI3_ASSERT(a_stall_hold, !en |=> $stable(r_vld_div), "valid line moved during stall")
endmodule

### test/mi3_result_checker.sv
// watches both channels, predicts each inverse and compares in order
module mi3_result_checker #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  mi3_pkg::t_mi3_in   i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mi3_pkg::t_mi3_out  i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import mi3_pkg::*;

    typedef logic signed [191:0] t_big;

    t_mi3_out inverse_queue[$];

    // signed quotient truncated toward zero, saturated to 32 bits
    function automatic t_word quot_sat(t_big num, t_big den, ref logic ovf);
        t_big q;
        q = num / den;
        if (q > t_big'(SAT_MAX)) begin
            ovf = 1'b1;
            return SAT_MAX;
        end
        if (q < t_big'(SAT_MIN)) begin
            ovf = 1'b1;
            return SAT_MIN;
        end
        return t_word'(q);
    endfunction

    function automatic t_mi3_out predict_inverse(t_mi3_in m);
        t_big a [3][3];
        t_big c [3][3];
        t_big det, piv;
        t_big abs0, abs1, abs2;
        t_word q;
        logic ovf;
        t_mi3_out r;
        t_word flat [9];
        a[0][0] = t_big'(m.in_r0c0); a[0][1] = t_big'(m.in_r0c1); a[0][2] = t_big'(m.in_r0c2);
        a[1][0] = t_big'(m.in_r1c0); a[1][1] = t_big'(m.in_r1c1); a[1][2] = t_big'(m.in_r1c2);
        a[2][0] = t_big'(m.in_r2c0); a[2][1] = t_big'(m.in_r2c1); a[2][2] = t_big'(m.in_r2c2);
        c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
        c[0][1] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
        c[0][2] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
        c[1][0] = a[2][1]*a[0][2] - a[2][2]*a[0][1];
        c[1][1] = a[2][2]*a[0][0] - a[2][0]*a[0][2];
        c[1][2] = a[2][0]*a[0][1] - a[2][1]*a[0][0];
        c[2][0] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
        c[2][1] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
        c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
        abs0 = a[0][0] < 0 ? -a[0][0] : a[0][0];
        abs1 = a[1][0] < 0 ? -a[1][0] : a[1][0];
        abs2 = a[2][0] < 0 ? -a[2][0] : a[2][0];
        // pivot from column 0, ties fall through toward row 2
        if (abs1 < abs0 && abs2 < abs0) begin
            piv = a[0][0];
            det = c[1][1]*c[2][2] - c[1][2]*c[2][1];
        end else if (abs0 < abs1 && abs2 < abs1) begin
            piv = a[1][0];
            det = c[0][2]*c[2][1] - c[0][1]*c[2][2];
        end else begin
            piv = a[2][0];
            det = c[1][2]*c[0][1] - c[1][1]*c[0][2];
        end
        if (det == 0) begin
            r = '0;
            r.out_r0c0 = m.in_r0c0; r.out_r0c1 = m.in_r0c1; r.out_r0c2 = m.in_r0c2;
            r.out_r1c0 = m.in_r1c0; r.out_r1c1 = m.in_r1c1; r.out_r1c2 = m.in_r1c2;
            r.out_r2c0 = m.in_r2c0; r.out_r2c1 = m.in_r2c1; r.out_r2c2 = m.in_r2c2;
            r.singular = 1'b1;
            return r;
        end
        piv = piv <<< (2 * FRAC_BITS);
        ovf = 1'b0;
        // inverse row i column j takes cofactor at j,i
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                q = quot_sat(piv * c[j][i], det, ovf);
                flat[i*3+j] = q;
            end
        r.out_r0c0 = flat[0]; r.out_r0c1 = flat[1]; r.out_r0c2 = flat[2];
        r.out_r1c0 = flat[3]; r.out_r1c1 = flat[4]; r.out_r1c2 = flat[5];
        r.out_r2c0 = flat[6]; r.out_r2c1 = flat[7]; r.out_r2c2 = flat[8];
        r.singular = 1'b0;
        r.overflow = ovf;
        return r;
    endfunction

    assign o_pending = inverse_queue.size();

    // record input beats, compare output beats
    always @(posedge i_clk) begin
        t_mi3_out want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                inverse_queue.push_back(predict_inverse(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (inverse_queue.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $realtime, i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = inverse_queue.pop_front();
                    if (want !== i_out_data) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $realtime, want, i_out_data);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### test/tb.sv
module tb;
    import mi3_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_off = 1'b0;

    mi3_stream_if #(.t_payload(t_mi3_in))  in_ch ();
    mi3_stream_if #(.t_payload(t_mi3_out)) out_ch ();

    matrix3x3_inverse DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    mi3_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_data    (in_ch.payload),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_data   (out_ch.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // receiver stalls at random, or holds off during pressure
    always @(posedge i_clk) begin
        out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_word rand_word();
        case ($urandom_range(5))
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(8) == 0 ? 0 : 1 << $urandom_range(31));
            2: return t_word'(int'($urandom_range(1 << 18)) - (1 << 17));
            3: return ($urandom_range(1)) ? SAT_MAX : SAT_MIN;
            default: return t_word'(int'($urandom_range(1 << 20)) - (1 << 19));
        endcase
    endfunction

    function automatic t_mi3_in rand_matrix();
        t_mi3_in m;
        m = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
             rand_word(), rand_word(), rand_word(), rand_word()};
        // sometimes make row 2 copy row 0 for a singular matrix
        if ($urandom_range(9) == 0) begin
            m.in_r2c0 = m.in_r0c0; m.in_r2c1 = m.in_r0c1; m.in_r2c2 = m.in_r0c2;
        end
        return m;
    endfunction

    task automatic send_matrix(input t_mi3_in m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= m;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    function automatic t_mi3_in diag(t_word d0, t_word d1, t_word d2);
        t_mi3_in m;
        m = '0;
        m.in_r0c0 = d0; m.in_r1c1 = d1; m.in_r2c2 = d2;
        return m;
    endfunction

    initial begin
        t_mi3_in m;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // identity, scaled, tiny and huge diagonals, zero, extremes
        send_matrix(diag(32'sh10000, 32'sh10000, 32'sh10000));
        send_matrix(diag(32'sh20000, -32'sh8000, 32'sh30000));
        send_matrix(diag(1, 1, 1));
        send_matrix(diag(SAT_MAX, SAT_MIN, SAT_MAX));
        send_matrix('0);
        send_matrix({9{SAT_MAX}});
        send_matrix({9{SAT_MIN}});
        send_matrix({9{32'shFFFFFFFF}});
        // permutations select pivot rows 1 and 2, and ties fall through
        m = '0; m.in_r1c0 = 32'sh10000; m.in_r0c1 = 32'sh10000; m.in_r2c2 = 32'sh10000;
        send_matrix(m);
        m = '0; m.in_r2c0 = -32'sh10000; m.in_r0c1 = 32'sh10000; m.in_r1c2 = 32'sh10000;
        send_matrix(m);
        m = {32'sh10000, 32'sh1, 32'sh2, -32'sh10000, 32'sh3, 32'sh4,
             32'sh10000, 32'sh5, 32'sh7};
        send_matrix(m);
        m = {32'sh10000, 32'sh1, 32'sh2, 32'sh10000, 32'sh3, 32'sh9, 32'sh0, 32'sh5, 32'sh7};
        send_matrix(m);
        // zero column 0 is singular
        m = {32'sh0, 32'sh1, 32'sh2, 32'sh0, 32'sh3, 32'sh4, 32'sh0, 32'sh5, 32'sh6};
        send_matrix(m);
        // near singular, saturates
        m = {32'sh10000, 32'sh10000, 32'sh0, 32'sh10000, 32'sh10001, 32'sh0,
             32'sh0, 32'sh0, 32'sh1};
        send_matrix(m);
        // sender idle and receiver stall phases with random matrices
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < 370; n++) send_matrix(rand_matrix());
        end
        // pressure: long hold-off while the sender keeps offering
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(posedge i_clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 120; n++) send_matrix(rand_matrix());
        join
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
